// ===== rtl/ulcm_pkg.sv =====
// Package for the UART line command matcher.
// Holds beat opcodes, character codes, command and prompt tables.
// No dependencies.
package ulcm_pkg;

    localparam int NUM_CMDS   = 6;
    localparam int PROMPT_LEN = 7;
    localparam int CMD_MAX    = 9;

    localparam logic OP_RX_BYTE  = 1'b0;
    localparam logic OP_TX_READY = 1'b1;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic [5:0] ALL_CMDS = 6'h3F;

    localparam logic [3:0] LED_BIT_ACT = 4'b1000;

    typedef logic [0:CMD_MAX-1][7:0] t_cmd_text;

    function automatic t_cmd_text cmd_text(input logic [2:0] idx);
        t_cmd_text t;
        case (idx)
            3'd0:    t = {"red on", 24'h0};
            3'd1:    t = {"red off", 16'h0};
            3'd2:    t = {"green on", 8'h0};
            3'd3:    t = "green off";
            3'd4:    t = {"blue on", 16'h0};
            3'd5:    t = {"blue off", 8'h0};
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [7:0] cmd_char(input logic [2:0] idx, input logic [3:0] pos);
        t_cmd_text t;
        t = cmd_text(idx);
        if (pos < 4'(CMD_MAX)) begin
            return t[pos];
        end
        return 8'h00;
    endfunction

    function automatic logic [3:0] cmd_len(input logic [2:0] idx);
        case (idx)
            3'd0:    return 4'd6;
            3'd1:    return 4'd7;
            3'd2:    return 4'd8;
            3'd3:    return 4'd9;
            3'd4:    return 4'd7;
            3'd5:    return 4'd8;
            default: return 4'd0;
        endcase
    endfunction

    // LED bit driven by each command: 0 red, 1 green, 2 blue
    function automatic logic [1:0] cmd_bit(input logic [2:0] idx);
        case (idx)
            3'd0, 3'd1: return 2'd0;
            3'd2, 3'd3: return 2'd1;
            3'd4, 3'd5: return 2'd2;
            default:    return 2'd0;
        endcase
    endfunction

    function automatic logic cmd_level(input logic [2:0] idx);
        case (idx)
            3'd1, 3'd3, 3'd5: return 1'b1;
            default:          return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] prompt_char(input logic [2:0] idx);
        case (idx)
            3'd0:    return 8'h0A;
            3'd1:    return "I";
            3'd2:    return "n";
            3'd3:    return "p";
            3'd4:    return "u";
            3'd5:    return "t";
            3'd6:    return ":";
            default: return 8'h00;
        endcase
    endfunction

endpackage

// ===== rtl/uart_line_command_matcher_top.sv =====
// UART line command matcher: line store, command match, echo with prompt.
// Depends on ulcm_pkg.
//
//  channel | handshake          | payload
//  in      | i_valid / o_ready  | i_opcode, i_rx_byte
//  out     | o_valid / i_ready  | o_tx_valid, o_tx_byte, o_red_led, o_green_led,
//          |                    | o_blue_led, o_activity_led, o_line_done
//
// One beat per cycle unless the output stalls; each input beat gives one output beat via stage 1 and the output stage.
// The line is kept in one half of a two-bank byte memory; a line end swaps
// banks, so the echo reads the ended line without a copy pass.
// Reset is synchronous, active low; memory contents are not cleared.
// A stalled output holds the output stage; a beat in stage 1 is held too, and then o_ready drops.
module uart_line_command_matcher_top #(
    parameter int LINE_DEPTH = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_opcode,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic       o_red_led,
    output logic       o_green_led,
    output logic       o_blue_led,
    output logic       o_activity_led,
    output logic       o_line_done
);
    import ulcm_pkg::*;

    localparam int AW        = $clog2(LINE_DEPTH);
    localparam int PW        = $clog2(LINE_DEPTH + PROMPT_LEN + 1);
    localparam int MEM_DEPTH = 2 * (1 << AW);

    logic [7:0]    r_mem [MEM_DEPTH];
    logic [7:0]    r_mem_q;

    logic [AW-1:0] r_line_len, n_line_len;
    logic          r_zero_seen, n_zero_seen;
    logic [AW-1:0] r_zero_pos, n_zero_pos;
    logic [5:0]    r_alive, n_alive;
    logic          r_line_bank, n_line_bank;
    logic [AW-1:0] r_echo_len, n_echo_len;
    logic [PW-1:0] r_echo_ptr, n_echo_ptr;
    logic          r_echo_active, n_echo_active;
    logic [3:0]    r_leds, n_leds;

    logic          r_s1_valid;
    logic          r_s1_tx_valid, n_s1_tx_valid;
    logic          r_s1_use_mem, n_s1_use_mem;
    logic [7:0]    r_s1_prompt, n_s1_prompt;
    logic [3:0]    r_s1_leds;
    logic          r_s1_done, n_s1_done;

    logic          r_o_valid;
    logic          r_o_tx_valid;
    logic [7:0]    r_o_tx_byte;
    logic [3:0]    r_o_leds;
    logic          r_o_done;

    logic          adv_out;
    logic          accept;
    logic          wr_en;
    logic [AW:0]   wr_addr;
    logic [AW:0]   rd_addr;
    logic [5:0]    alive_end;
    logic [2:0]    sel;
    logic          found;
    logic [PW-1:0] total;
    logic [PW-1:0] prompt_off;

    assign adv_out = !r_o_valid || i_ready;
    assign o_ready = !r_s1_valid || adv_out;
    assign accept  = i_valid && o_ready;

    assign wr_addr = {r_line_bank, r_line_len};
    assign rd_addr = {!r_line_bank, r_echo_ptr[AW-1:0]};
    assign total   = PW'(r_echo_len) + PW'(PROMPT_LEN);
    assign prompt_off = r_echo_ptr - PW'(r_echo_len);

    always_comb begin
        n_line_len    = r_line_len;
        n_zero_seen   = r_zero_seen;
        n_zero_pos    = r_zero_pos;
        n_alive       = r_alive;
        n_line_bank   = r_line_bank;
        n_echo_len    = r_echo_len;
        n_echo_ptr    = r_echo_ptr;
        n_echo_active = r_echo_active;
        n_leds        = r_leds;
        n_s1_tx_valid = 1'b0;
        n_s1_use_mem  = 1'b0;
        n_s1_prompt   = 8'h00;
        n_s1_done     = 1'b0;
        wr_en         = 1'b0;
        alive_end     = r_alive;
        sel           = 3'd0;
        found         = 1'b0;

        if (i_opcode == OP_RX_BYTE) begin
            if (i_rx_byte == CHAR_CR || i_rx_byte == CHAR_LF) begin
                if (!r_zero_seen) begin
                    for (int i = 0; i < NUM_CMDS; i++) begin
                        if (AW'(cmd_len(3'(i))) != r_line_len) begin
                            alive_end[i] = 1'b0;
                        end
                    end
                end
                for (int i = NUM_CMDS - 1; i >= 0; i--) begin
                    if (alive_end[i]) begin
                        sel   = 3'(i);
                        found = 1'b1;
                    end
                end
                if (found) begin
                    n_leds[cmd_bit(sel)] = cmd_level(sel);
                end
                n_echo_len    = r_zero_seen ? r_zero_pos : r_line_len;
                n_echo_active = 1'b1;
                n_line_bank   = !r_line_bank;
                n_line_len    = '0;
                n_zero_seen   = 1'b0;
                n_alive       = ALL_CMDS;
                n_s1_done     = 1'b1;
            end else if (r_line_len >= AW'(LINE_DEPTH - 1)) begin
                n_line_len  = '0;
                n_zero_seen = 1'b0;
                n_alive     = ALL_CMDS;
            end else begin
                wr_en      = 1'b1;
                n_line_len = r_line_len + 1'b1;
                if (!r_zero_seen) begin
                    if (i_rx_byte == 8'h00) begin
                        n_zero_seen = 1'b1;
                        n_zero_pos  = r_line_len;
                        for (int i = 0; i < NUM_CMDS; i++) begin
                            if (AW'(cmd_len(3'(i))) != r_line_len) begin
                                n_alive[i] = 1'b0;
                            end
                        end
                    end else begin
                        for (int i = 0; i < NUM_CMDS; i++) begin
                            if (r_line_len >= AW'(cmd_len(3'(i)))) begin
                                n_alive[i] = 1'b0;
                            end else if (cmd_char(3'(i), r_line_len[3:0]) != i_rx_byte) begin
                                n_alive[i] = 1'b0;
                            end
                        end
                    end
                end
            end
        end else if (r_echo_active) begin
            n_leds = r_leds ^ LED_BIT_ACT;
            if (r_echo_ptr < total) begin
                n_s1_tx_valid = 1'b1;
                n_s1_use_mem  = r_echo_ptr < PW'(r_echo_len);
                n_s1_prompt   = prompt_char(prompt_off[2:0]);
                n_echo_ptr    = r_echo_ptr + 1'b1;
            end else begin
                n_echo_ptr    = '0;
                n_echo_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (wr_en) begin
                r_mem[wr_addr] <= i_rx_byte;
            end
            r_mem_q <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len    <= '0;
            r_zero_seen   <= 1'b0;
            r_alive       <= ALL_CMDS;
            r_line_bank   <= 1'b0;
            r_echo_len    <= '0;
            r_echo_ptr    <= '0;
            r_echo_active <= 1'b0;
            r_leds        <= 4'hF;
        end else if (accept) begin
            r_line_len    <= n_line_len;
            r_zero_seen   <= n_zero_seen;
            r_alive       <= n_alive;
            r_line_bank   <= n_line_bank;
            r_echo_len    <= n_echo_len;
            r_echo_ptr    <= n_echo_ptr;
            r_echo_active <= n_echo_active;
            r_leds        <= n_leds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_zero_pos    <= n_zero_pos;
            r_s1_tx_valid <= n_s1_tx_valid;
            r_s1_use_mem  <= n_s1_use_mem;
            r_s1_prompt   <= n_s1_prompt;
            r_s1_leds     <= n_leds;
            r_s1_done     <= n_s1_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (adv_out) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_s1_valid) begin
            r_o_tx_valid <= r_s1_tx_valid;
            r_o_tx_byte  <= !r_s1_tx_valid ? 8'h00 :
                            (r_s1_use_mem ? r_mem_q : r_s1_prompt);
            r_o_leds     <= r_s1_leds;
            r_o_done     <= r_s1_done;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_tx_valid     = r_o_tx_valid;
    assign o_tx_byte      = r_o_tx_byte;
    assign o_red_led      = r_o_leds[0];
    assign o_green_led    = r_o_leds[1];
    assign o_blue_led     = r_o_leds[2];
    assign o_activity_led = r_o_leds[3];
    assign o_line_done    = r_o_done;

endmodule
